FILE: hdl/sprite_rect_scissor_clip_top_macros.svh
// Assertion macros shared by the checker.
`ifndef SPRITE_RECT_SCISSOR_CLIP_TOP_MACROS_SVH
`define SPRITE_RECT_SCISSOR_CLIP_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SRSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SRSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checks the cycle after each clock edge that samples reset high.
`define SRSC_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: hdl/srsc_pkg.sv
`timescale 1ns / 1ps
package srsc_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int SIZE_W       = COORD_WIDTH - 1;
  localparam int TEX_W        = 24;
  localparam int UV_W         = 24;
  localparam int UV_FRAC_BITS = 20;
  localparam int TEXEL_FRAC   = 8;
  localparam int INV_FRAC     = 23;
  localparam int MIX_FRAC     = 24;
  localparam int ROUND_SHIFT  = TEXEL_FRAC + INV_FRAC - UV_FRAC_BITS;
  localparam int PROD_W       = TEX_W + 1 + TEX_W;
  localparam int UV_FULL_W    = PROD_W - ROUND_SHIFT;
  localparam int DEPTH_W      = 16;
  localparam int COLOR_W      = 32;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES   = MIX_FRAC / BITS_PER_STAGE;
  localparam int SIDE_DELAY   = DIV_STAGES - 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = COORD_WIDTH;
  localparam int LANES        = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_VALUE = 3'd5;

  typedef enum logic [2:0] {
    FR_ZERO = 3'b001,
    FR_ONE  = 3'b010,
    FR_DIV  = 3'b100
  } frac_mode_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic [SIZE_W-1:0]             rect_w;
    logic [SIZE_W-1:0]             rect_h;
    logic [TEX_W-1:0]              src_x;
    logic [TEX_W-1:0]              src_y;
    logic [TEX_W-1:0]              src_w;
    logic [TEX_W-1:0]              src_h;
    logic [TEX_W-1:0]              inv_tex_width;
    logic [TEX_W-1:0]              inv_tex_height;
    logic [COLOR_W-1:0]            color_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x0;
    logic signed [COORD_WIDTH-1:0] out_y0;
    logic signed [COORD_WIDTH-1:0] out_x1;
    logic signed [COORD_WIDTH-1:0] out_y1;
    logic [UV_W-1:0]               out_u0;
    logic [UV_W-1:0]               out_v0;
    logic [UV_W-1:0]               out_u1;
    logic [UV_W-1:0]               out_v1;
    logic [COLOR_W-1:0]            out_color;
    logic signed [DEPTH_W-1:0]     out_depth;
  } out_item_t;

  typedef struct packed {
    logic                          enable;
    logic signed [COORD_WIDTH-1:0] left;
    logic signed [COORD_WIDTH-1:0] top;
    logic [SIZE_W-1:0]             width;
    logic [SIZE_W-1:0]             height;
    logic signed [DEPTH_W-1:0]     depth;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] num;
    logic [SIZE_W-1:0] den;
    frac_mode_t        mode;
  } div_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x0;
    logic signed [COORD_WIDTH-1:0] y0;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic [UV_FULL_W-1:0]          u0;
    logic [UV_FULL_W-1:0]          v0;
    logic [UV_FULL_W-1:0]          du;
    logic [UV_FULL_W-1:0]          dv;
    logic [COLOR_W-1:0]            color;
  } side_t;

endpackage

FILE: hdl/srsc_front.sv
`timescale 1ns / 1ps
module srsc_front import srsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  in_item_t             in_item,
  input  cfg_t                 cfg,
  output div_in_t [LANES-1:0]  div_in,
  output side_t                side,
  output logic                 side_valid
);

  localparam int EXT_W = COORD_WIDTH + 1;

  function automatic frac_mode_t pick_mode(input logic on, input logic far_edge,
                                           input logic [SIZE_W-1:0] num,
                                           input logic [SIZE_W-1:0] den);
    frac_mode_t m;
    if (!on) begin
      m = far_edge ? FR_ONE : FR_ZERO;
    end else if (den == '0 || num == '0) begin
      m = FR_ZERO;
    end else if (num >= den) begin
      m = FR_ONE;
    end else begin
      m = FR_DIV;
    end
    return m;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [COORD_WIDTH-1:0] r;
    hi = EXT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - EXT_W'(1);
    if (v > hi) begin
      r = hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      r = lo[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // Stage 1
  logic                          v1;
  logic signed [COORD_WIDTH-1:0] x1_q, y1_q;
  logic [SIZE_W-1:0]             w1, h1;
  logic signed [EXT_W-1:0]       xe1, ye1, cx2_1, cy2_1;
  logic [TEX_W:0]                tu0_1, tu1_1, tv0_1, tv1_1;
  logic [TEX_W-1:0]              iw1, ih1;
  logic [COLOR_W-1:0]            col1;

  // Stage 2
  logic                          v2, on2;
  logic signed [COORD_WIDTH-1:0] x0c2, y0c2;
  logic signed [EXT_W-1:0]       x1c2, y1c2;
  logic [SIZE_W-1:0]             nx0_2, nx1_2, ny0_2, ny1_2, w2, h2;
  logic [PROD_W-1:0]             pu0_2, pu1_2, pv0_2, pv1_2;
  logic [COLOR_W-1:0]            col2;

  // Stage 3
  logic                          v3;
  logic signed [COORD_WIDTH-1:0] x0_3, y0_3, x1_3, y1_3;
  logic [UV_FULL_W-1:0]          u0_3, u1_3, v0_3, v1_3;
  logic [COLOR_W-1:0]            col3;
  div_in_t [LANES-1:0]           div3;

  // Stage 4
  logic                          v4;
  side_t                         side4;

  logic                          outside;
  logic                          keep;
  logic signed [EXT_W-1:0]       x_e, y_e, x0_sel, y0_sel;
  logic signed [EXT_W-1:0]       x1_sel, y1_sel;
  logic signed [EXT_W-1:0]       cl_e, ct_e;
  logic signed [EXT_W:0]         nx0_f, nx1_f, ny0_f, ny1_f;
  logic [PROD_W-1:0]             rnd;

  assign x_e  = EXT_W'(x1_q);
  assign y_e  = EXT_W'(y1_q);
  assign cl_e = EXT_W'(cfg.left);
  assign ct_e = EXT_W'(cfg.top);
  assign rnd  = PROD_W'(1) << (ROUND_SHIFT - 1);

  always_comb begin
    outside = (cl_e > xe1) || (cx2_1 < x_e) || (ct_e > ye1) || (cy2_1 < y_e);
    keep    = !cfg.enable || !outside;
    x0_sel  = (cfg.enable && cl_e > x_e) ? cl_e : x_e;
    y0_sel  = (cfg.enable && ct_e > y_e) ? ct_e : y_e;
    x1_sel  = (cfg.enable && cx2_1 < xe1) ? cx2_1 : xe1;
    y1_sel  = (cfg.enable && cy2_1 < ye1) ? cy2_1 : ye1;
    nx0_f   = (EXT_W+1)'(x0_sel) - (EXT_W+1)'(x_e);
    nx1_f   = (EXT_W+1)'(x1_sel) - (EXT_W+1)'(x_e);
    ny0_f   = (EXT_W+1)'(y0_sel) - (EXT_W+1)'(y_e);
    ny1_f   = (EXT_W+1)'(y1_sel) - (EXT_W+1)'(y_e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1 && keep;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_q  <= in_item.pos_x;
      y1_q  <= in_item.pos_y;
      w1    <= in_item.rect_w;
      h1    <= in_item.rect_h;
      xe1   <= EXT_W'(in_item.pos_x) + $signed({2'b00, in_item.rect_w});
      ye1   <= EXT_W'(in_item.pos_y) + $signed({2'b00, in_item.rect_h});
      cx2_1 <= EXT_W'(cfg.left) + $signed({2'b00, cfg.width});
      cy2_1 <= EXT_W'(cfg.top) + $signed({2'b00, cfg.height});
      tu0_1 <= {1'b0, in_item.src_x};
      tv0_1 <= {1'b0, in_item.src_y};
      tu1_1 <= {1'b0, in_item.src_x} + {1'b0, in_item.src_w};
      tv1_1 <= {1'b0, in_item.src_y} + {1'b0, in_item.src_h};
      iw1   <= in_item.inv_tex_width;
      ih1   <= in_item.inv_tex_height;
      col1  <= in_item.color_in;

      on2   <= cfg.enable;
      x0c2  <= x0_sel[COORD_WIDTH-1:0];
      y0c2  <= y0_sel[COORD_WIDTH-1:0];
      x1c2  <= x1_sel;
      y1c2  <= y1_sel;
      nx0_2 <= nx0_f[SIZE_W-1:0];
      nx1_2 <= nx1_f[SIZE_W-1:0];
      ny0_2 <= ny0_f[SIZE_W-1:0];
      ny1_2 <= ny1_f[SIZE_W-1:0];
      w2    <= w1;
      h2    <= h1;
      pu0_2 <= PROD_W'(tu0_1) * PROD_W'(iw1);
      pu1_2 <= PROD_W'(tu1_1) * PROD_W'(iw1);
      pv0_2 <= PROD_W'(tv0_1) * PROD_W'(ih1);
      pv1_2 <= PROD_W'(tv1_1) * PROD_W'(ih1);
      col2  <= col1;

      x0_3  <= x0c2;
      y0_3  <= y0c2;
      x1_3  <= sat_coord(x1c2);
      y1_3  <= sat_coord(y1c2);
      u0_3  <= UV_FULL_W'((pu0_2 + rnd) >> ROUND_SHIFT);
      u1_3  <= UV_FULL_W'((pu1_2 + rnd) >> ROUND_SHIFT);
      v0_3  <= UV_FULL_W'((pv0_2 + rnd) >> ROUND_SHIFT);
      v1_3  <= UV_FULL_W'((pv1_2 + rnd) >> ROUND_SHIFT);
      col3  <= col2;
      div3[0] <= '{num: nx0_2, den: w2, mode: pick_mode(on2, 1'b0, nx0_2, w2)};
      div3[1] <= '{num: ny0_2, den: h2, mode: pick_mode(on2, 1'b0, ny0_2, h2)};
      div3[2] <= '{num: nx1_2, den: w2, mode: pick_mode(on2, 1'b1, nx1_2, w2)};
      div3[3] <= '{num: ny1_2, den: h2, mode: pick_mode(on2, 1'b1, ny1_2, h2)};

      side4.x0    <= x0_3;
      side4.y0    <= y0_3;
      side4.x1    <= x1_3;
      side4.y1    <= y1_3;
      side4.u0    <= u0_3;
      side4.v0    <= v0_3;
      side4.du    <= (u1_3 >= u0_3) ? (u1_3 - u0_3) : '0;
      side4.dv    <= (v1_3 >= v0_3) ? (v1_3 - v0_3) : '0;
      side4.color <= col3;
    end
  end

  assign div_in     = div3;
  assign side       = side4;
  assign side_valid = v4;

endmodule

FILE: hdl/srsc_div.sv
`timescale 1ns / 1ps
module srsc_div import srsc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  div_in_t           din,
  output logic [MIX_FRAC:0] frac
);

  localparam int REM_W = SIZE_W + 1;

  logic [REM_W-1:0]    rem_q  [0:DIV_STAGES-1];
  logic [MIX_FRAC-1:0] quo_q  [0:DIV_STAGES-1];
  logic [SIZE_W-1:0]   den_q  [0:DIV_STAGES-1];
  frac_mode_t          mode_q [0:DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0]    rem_in;
    logic [MIX_FRAC-1:0] quo_in;
    logic [SIZE_W-1:0]   den_in;
    frac_mode_t          mode_in;
    logic [REM_W-1:0]    rem_out;
    logic [MIX_FRAC-1:0] quo_out;

    if (s == 0) begin : g_first
      assign rem_in  = REM_W'(din.num);
      assign quo_in  = '0;
      assign den_in  = din.den;
      assign mode_in = din.mode;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign mode_in = mode_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] t;
      rem_out = rem_in;
      quo_out = quo_in;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t = {rem_out[REM_W-2:0], 1'b0};
        if (t >= REM_W'(den_in)) begin
          rem_out = t - REM_W'(den_in);
          quo_out = {quo_out[MIX_FRAC-2:0], 1'b1};
        end else begin
          rem_out = t;
          quo_out = {quo_out[MIX_FRAC-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_out;
        quo_q[s]  <= quo_out;
        den_q[s]  <= den_in;
        mode_q[s] <= mode_in;
      end
    end
  end

  always_comb begin
    case (mode_q[DIV_STAGES-1])
      FR_ONE:  frac = (MIX_FRAC+1)'(1) << MIX_FRAC;
      FR_DIV:  frac = {1'b0, quo_q[DIV_STAGES-1]};
      default: frac = '0;
    endcase
  end

endmodule

FILE: hdl/srsc_lerp.sv
`timescale 1ns / 1ps
module srsc_lerp import srsc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [UV_FULL_W-1:0] t0,
  input  logic [UV_FULL_W-1:0] d,
  input  logic [MIX_FRAC:0]    f,
  output logic [UV_W-1:0]      uv
);

  localparam int LO_W  = MIX_FRAC;
  localparam int HI_W  = UV_FULL_W - LO_W;
  localparam int PL_W  = LO_W + MIX_FRAC + 1;
  localparam int PH_W  = HI_W + MIX_FRAC + 1;
  localparam int SUM_W = UV_FULL_W + MIX_FRAC + 2;
  localparam logic [SUM_W-1:0] UV_MAX = SUM_W'({UV_W{1'b1}});

  logic [PL_W-1:0]      pl;
  logic [PH_W-1:0]      ph;
  logic [UV_FULL_W-1:0] t0_q;
  logic [SUM_W-1:0]     sum;

  assign sum = SUM_W'(t0_q) + SUM_W'(ph)
             + SUM_W'((pl + (PL_W'(1) << (MIX_FRAC - 1))) >> MIX_FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      pl   <= PL_W'(d[LO_W-1:0]) * PL_W'(f);
      ph   <= PH_W'(d[UV_FULL_W-1:LO_W]) * PH_W'(f);
      t0_q <= t0;
      uv   <= (sum > UV_MAX) ? UV_MAX[UV_W-1:0] : sum[UV_W-1:0];
    end
  end

endmodule

FILE: hdl/sprite_rect_scissor_clip_top.sv
// Throughput: one item per cycle while the output is not stalled.
// The 12-stage fraction divider sets the depth.
// A stall on the output freezes every stage; a clipped-away item leaves no result.
// Reset (rst, synchronous, active high) clears all valid bits and the clip config.
`timescale 1ns / 1ps
module sprite_rect_scissor_clip_top import srsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  in_item_t              req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output out_item_t             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg;
  logic                adv;
  div_in_t [LANES-1:0] div_in;
  side_t               side4;
  logic                v4;
  logic [MIX_FRAC:0]   frac [0:LANES-1];
  logic [UV_W-1:0]     uv   [0:LANES-1];
  side_t               side_q [0:SIDE_DELAY-1];
  logic                vd     [0:SIDE_DELAY-1];
  side_t               side16, side17;
  logic                v16, v17;

  assign adv       = !v17 || rsp_ready;
  assign req_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_ENABLE: cfg.enable <= cfg_data[0];
        CFG_CLIP_LEFT:   cfg.left   <= cfg_data[COORD_WIDTH-1:0];
        CFG_CLIP_TOP:    cfg.top    <= cfg_data[COORD_WIDTH-1:0];
        CFG_CLIP_WIDTH:  cfg.width  <= cfg_data[SIZE_W-1:0];
        CFG_CLIP_HEIGHT: cfg.height <= cfg_data[SIZE_W-1:0];
        CFG_DEPTH_VALUE: cfg.depth  <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  srsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (req_valid),
    .in_item    (req),
    .cfg        (cfg),
    .div_in     (div_in),
    .side       (side4),
    .side_valid (v4)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_div
    srsc_div u_div (
      .clk  (clk),
      .en   (adv),
      .din  (div_in[l]),
      .frac (frac[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_DELAY; i++) begin
        vd[i] <= 1'b0;
      end
      v16 <= 1'b0;
      v17 <= 1'b0;
    end else if (adv) begin
      vd[0] <= v4;
      for (int i = 1; i < SIDE_DELAY; i++) begin
        vd[i] <= vd[i-1];
      end
      v16 <= vd[SIDE_DELAY-1];
      v17 <= v16;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side4;
      for (int i = 1; i < SIDE_DELAY; i++) begin
        side_q[i] <= side_q[i-1];
      end
      side16 <= side_q[SIDE_DELAY-1];
      side17 <= side16;
    end
  end

  srsc_lerp u_lerp_u0 (
    .clk (clk), .en (adv), .t0 (side_q[SIDE_DELAY-1].u0),
    .d (side_q[SIDE_DELAY-1].du), .f (frac[0]), .uv (uv[0])
  );
  srsc_lerp u_lerp_v0 (
    .clk (clk), .en (adv), .t0 (side_q[SIDE_DELAY-1].v0),
    .d (side_q[SIDE_DELAY-1].dv), .f (frac[1]), .uv (uv[1])
  );
  srsc_lerp u_lerp_u1 (
    .clk (clk), .en (adv), .t0 (side_q[SIDE_DELAY-1].u0),
    .d (side_q[SIDE_DELAY-1].du), .f (frac[2]), .uv (uv[2])
  );
  srsc_lerp u_lerp_v1 (
    .clk (clk), .en (adv), .t0 (side_q[SIDE_DELAY-1].v0),
    .d (side_q[SIDE_DELAY-1].dv), .f (frac[3]), .uv (uv[3])
  );

  assign rsp_valid     = v17;
  assign rsp.out_x0    = side17.x0;
  assign rsp.out_y0    = side17.y0;
  assign rsp.out_x1    = side17.x1;
  assign rsp.out_y1    = side17.y1;
  assign rsp.out_u0    = uv[0];
  assign rsp.out_v0    = uv[1];
  assign rsp.out_u1    = uv[2];
  assign rsp.out_v1    = uv[3];
  assign rsp.out_color = side17.color;
  assign rsp.out_depth = cfg.depth;

endmodule

FILE: hdl/srsc_chk.sv
`timescale 1ns / 1ps
`include "sprite_rect_scissor_clip_top_macros.svh"
module srsc_chk import srsc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_item_t rsp
);

  `SRSC_ASSERT_RST(a_rst_empty, !rsp_valid, "result valid right after reset")
  `SRSC_ASSERT_IMP(a_ready_link, 1'b1, req_ready == (!rsp_valid || rsp_ready), "ready mismatch")
  `SRSC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped in stall")
  `SRSC_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp), "result changed in stall")

endmodule

bind sprite_rect_scissor_clip_top srsc_chk u_srsc_chk (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import srsc_pkg::*;

  localparam int LATENCY     = 17;
  localparam int WATCHDOG    = 20000;

  class clip_scoreboard;
    out_item_t pending[$];
    int        errors;
    logic      en;
    longint    left, top, cw, ch;
    logic [15:0] depth;

    function new();
      errors = 0;
      en = 0; left = 0; top = 0; cw = 0; ch = 0; depth = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CLIP_ENABLE: en = val[0];
        CFG_CLIP_LEFT:   left = longint'(signed'(val));
        CFG_CLIP_TOP:    top = longint'(signed'(val));
        CFG_CLIP_WIDTH:  cw = longint'(val[SIZE_W-1:0]);
        CFG_CLIP_HEIGHT: ch = longint'(val[SIZE_W-1:0]);
        CFG_DEPTH_VALUE: depth = val[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned tex_coord(longint unsigned texel, longint unsigned inv);
      longint unsigned p;
      p = texel * inv;
      return (p + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    endfunction

    function longint unsigned lerp(longint unsigned t0, longint unsigned t1,
                                   longint unsigned f);
      longint unsigned d, r;
      d = (t1 >= t0) ? t1 - t0 : 0;
      r = t0 + ((d * f + (64'd1 << (MIX_FRAC - 1))) >> MIX_FRAC);
      return (r > 64'hFFFFFF) ? 64'hFFFFFF : r;
    endfunction

    function longint unsigned fraction(longint num, longint den);
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return 64'd1 << MIX_FRAC;
      return (longint'(num) << MIX_FRAC) / den;
    endfunction

    function logic [23:0] sat(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
    endfunction

    function void note_input(in_item_t it);
      longint x, y, w, h, x0, y0, x1, y1;
      longint unsigned u0, u1, v0, v1, fx0, fy0, fx1, fy1;
      out_item_t o;
      x = longint'(it.pos_x); y = longint'(it.pos_y);
      w = longint'(it.rect_w); h = longint'(it.rect_h);
      x0 = x; y0 = y; x1 = x + w; y1 = y + h;
      fx0 = 0; fy0 = 0; fx1 = 64'd1 << MIX_FRAC; fy1 = fx1;
      u0 = tex_coord(64'(it.src_x), 64'(it.inv_tex_width));
      u1 = tex_coord(64'(it.src_x) + 64'(it.src_w), 64'(it.inv_tex_width));
      v0 = tex_coord(64'(it.src_y), 64'(it.inv_tex_height));
      v1 = tex_coord(64'(it.src_y) + 64'(it.src_h), 64'(it.inv_tex_height));
      if (en) begin
        if (left > x1 || left + cw < x0 || top > y1 || top + ch < y0) return;
        if (left > x0) x0 = left;
        if (left + cw < x1) x1 = left + cw;
        if (top > y0) y0 = top;
        if (top + ch < y1) y1 = top + ch;
        fx0 = fraction(x0 - x, w);
        fx1 = fraction(x1 - x, w);
        fy0 = fraction(y0 - y, h);
        fy1 = fraction(y1 - y, h);
      end
      o.out_x0 = sat(x0); o.out_y0 = sat(y0);
      o.out_x1 = sat(x1); o.out_y1 = sat(y1);
      o.out_u0 = 24'(lerp(u0, u1, fx0)); o.out_v0 = 24'(lerp(v0, v1, fy0));
      o.out_u1 = 24'(lerp(u0, u1, fx1)); o.out_v1 = 24'(lerp(v0, v1, fy1));
      o.out_color = it.color_in;
      o.out_depth = depth;
      pending = {pending, o};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_x0 !== e.out_x0) begin $error("out_x0 exp %h got %h", e.out_x0, got.out_x0); errors++; end
      if (got.out_y0 !== e.out_y0) begin $error("out_y0 exp %h got %h", e.out_y0, got.out_y0); errors++; end
      if (got.out_x1 !== e.out_x1) begin $error("out_x1 exp %h got %h", e.out_x1, got.out_x1); errors++; end
      if (got.out_y1 !== e.out_y1) begin $error("out_y1 exp %h got %h", e.out_y1, got.out_y1); errors++; end
      if (got.out_u0 !== e.out_u0) begin $error("out_u0 exp %h got %h", e.out_u0, got.out_u0); errors++; end
      if (got.out_v0 !== e.out_v0) begin $error("out_v0 exp %h got %h", e.out_v0, got.out_v0); errors++; end
      if (got.out_u1 !== e.out_u1) begin $error("out_u1 exp %h got %h", e.out_u1, got.out_u1); errors++; end
      if (got.out_v1 !== e.out_v1) begin $error("out_v1 exp %h got %h", e.out_v1, got.out_v1); errors++; end
      if (got.out_color !== e.out_color) begin
        $error("out_color exp %h got %h", e.out_color, got.out_color); errors++;
      end
      if (got.out_depth !== e.out_depth) begin
        $error("out_depth exp %h got %h", e.out_depth, got.out_depth); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  out_item_t rsp;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CLIP_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  clip_scoreboard board = new();

  sprite_rect_scissor_clip_top dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) board.check_result(rsp);
      if (req_valid && req_ready) board.note_input(req);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("tb_top failed");
        $finish;
      end
    end
    rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1; req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [23:0] rnd_coord(int span);
    int v;
    v = $urandom_range(2 * span) - span;
    return v[23:0];
  endfunction

  function automatic in_item_t rnd_item(bit wide);
    in_item_t it;
    it.color_in = $urandom;
    if (wide) begin
      it.pos_x = 24'($urandom); it.pos_y = 24'($urandom);
      it.rect_w = 23'($urandom); it.rect_h = 23'($urandom);
      it.src_x = 24'($urandom); it.src_y = 24'($urandom);
      it.src_w = 24'($urandom); it.src_h = 24'($urandom);
      it.inv_tex_width = 24'($urandom_range(8388608));
      it.inv_tex_height = 24'($urandom_range(8388608));
    end else begin
      it.pos_x = rnd_coord(40000); it.pos_y = rnd_coord(40000);
      it.rect_w = ($urandom_range(7) == 0) ? 23'd0 : 23'($urandom_range(30000));
      it.rect_h = ($urandom_range(7) == 0) ? 23'd0 : 23'($urandom_range(30000));
      it.src_x = 24'($urandom_range(65535)); it.src_y = 24'($urandom_range(65535));
      it.src_w = 24'($urandom_range(65535)); it.src_h = 24'($urandom_range(65535));
      it.inv_tex_width = 24'($urandom_range(8388608) >> $urandom_range(12));
      it.inv_tex_height = 24'($urandom_range(8388608) >> $urandom_range(12));
    end
    return it;
  endfunction

  task automatic set_clip(bit en, logic [23:0] l, logic [23:0] t, logic [22:0] w,
                          logic [22:0] h, logic [15:0] d);
    drain();
    write_reg(CFG_CLIP_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_CLIP_LEFT, l);
    write_reg(CFG_CLIP_TOP, t);
    write_reg(CFG_CLIP_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_CLIP_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_DEPTH_VALUE, CFG_DATA_W'(d));
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    in_item_t it;
    it = '0;
    send(it);
    it = '1; it.inv_tex_width = 24'd8388608; it.inv_tex_height = 24'd8388608;
    send(it);
    it.pos_x = 24'h7FFFFF; it.pos_y = 24'h7FFFFF; it.rect_w = '1; it.rect_h = '1;
    send(it);
    it.pos_x = 24'h800000; it.pos_y = 24'h800000;
    send(it);
    set_clip(1'b1, 24'd1000, 24'd1000, 23'd2000, 23'd2000, 16'h8000);
    it = rnd_item(1'b0);
    it.pos_x = 24'sd0; it.pos_y = 24'sd0; it.rect_w = 23'd1000; it.rect_h = 23'd1000;
    send(it);
    it.pos_x = 24'sd3000; it.pos_y = 24'sd3000;
    send(it);
    it.pos_x = 24'sd3001;
    send(it);
    it.pos_x = -24'sd2000; it.pos_y = 24'sd500; it.rect_w = 23'd6000; it.rect_h = 23'd4000;
    send(it);
    it.pos_x = 24'sd1500; it.rect_w = 23'd0;
    send(it);
    it.rect_w = 23'd100; it.rect_h = 23'd0; it.pos_y = 24'sd1500;
    send(it);
    it.pos_x = 24'sd1100; it.pos_y = 24'sd1100; it.rect_w = 23'd10; it.rect_h = 23'd10;
    send(it);
    drain();
    set_clip(1'b1, 24'd500, 24'd500, 23'd0, 23'd0, 16'h7FFF);
    it.pos_x = 24'sd0; it.pos_y = 24'sd0; it.rect_w = 23'd500; it.rect_h = 23'd500;
    send(it);
    it.pos_x = 24'sd400; it.pos_y = 24'sd400; it.rect_w = 23'd200; it.rect_h = 23'd200;
    send(it);
    it.pos_x = 24'sd501;
    send(it);
    drain();
    set_clip(1'b1, 24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'h1234);
    it = rnd_item(1'b1); send(it);
    it = rnd_item(1'b1); send(it);
    drain();
    set_clip(1'b1, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'h0);
    it = rnd_item(1'b1); it.pos_x = 24'h7FFFF0; it.pos_y = 24'h7FFFF0;
    send(it);
    drain();
  endtask

  task automatic random_phase(int n, int sidle, int rstall, bit en);
    int i;
    send_idle_pct = sidle; recv_stall_pct = rstall;
    set_clip(en, rnd_coord(20000), rnd_coord(20000), 23'($urandom_range(40000)),
             23'($urandom_range(40000)), 16'($urandom));
    for (i = 0; i < n; i++) send(rnd_item($urandom_range(9) == 0));
    drain();
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    random_phase(80, 0, 0, 1'b1);
    random_phase(80, 58, 0, 1'b1);
    random_phase(80, 0, 58, 1'b1);
    random_phase(60, 12, 12, 1'b0);
    random_phase(80, 12, 12, 1'b1);
    send_idle_pct = 0; recv_stall_pct = 0;
    set_clip(1'b0, '0, '0, '0, '0, 16'h00FF);
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      for (i = 0; i < 60; i++) send(rnd_item(1'b0));
    join
    drain();
    random_phase(20, 0, 0, 1'b1);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
